// File: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL; define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_HOLDS(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_HOLDS(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// File: rtl/core/usbfp_pkg.sv
// Types, constants and codes shared by the USB serial FIFO packetiser.
`timescale 1ns / 1ps
package usbfp_pkg;

	localparam int FIFO_DEPTH = 1024;
	localparam int AW         = $clog2(FIFO_DEPTH);
	localparam int IW         = AW + 1;

	localparam int MP_W       = 7;
	localparam int S_DATA_W   = 16;
	localparam int M_DATA_W   = 24;
	localparam int RXC_W      = 11;

	localparam logic [MP_W-1:0] MP_MIN   = 7'd8;
	localparam logic [MP_W-1:0] MP_MAX   = 7'd64;
	localparam logic [MP_W-1:0] MP_RESET = 7'd64;

	localparam logic [2:0] OP_HOST_IN  = 3'd0;
	localparam logic [2:0] OP_APP_READ = 3'd1;
	localparam logic [2:0] OP_APP_SEND = 3'd2;
	localparam logic [2:0] OP_FRAME    = 3'd3;
	localparam logic [2:0] OP_LINE     = 3'd4;

	localparam logic [2:0] KIND_DONE     = 3'd0;
	localparam logic [2:0] KIND_RD_BYTE  = 3'd1;
	localparam logic [2:0] KIND_RD_EMPTY = 3'd2;
	localparam logic [2:0] KIND_PKT_BYTE = 3'd3;
	localparam logic [2:0] KIND_ZLP      = 3'd4;

	localparam logic [7:0] CHR_CR = 8'h0D;
	localparam logic [7:0] CHR_LF = 8'h0A;

	typedef enum logic [1:0] {
		BSEL_ZERO,
		BSEL_RX,
		BSEL_TX
	} bsel_t;

	typedef struct packed {
		logic       cap;
		logic       rx_push;
		logic       rx_pop;
		logic       tx_push_cr;
		logic       tx_push_data;
		logic       tx_pop;
		logic       set_ls;
		logic       plan;
		logic       zlp_clr;
		logic       zlp_upd;
		logic       out_load;
		logic       out_last;
		logic [2:0] out_kind;
		bsel_t      out_bsel;
	} cmd_t;

	typedef struct packed {
		logic [2:0] op;
		logic       cr_needed;
		logic       rx_empty;
		logic       tx_empty;
		logic       tx_go;
		logic       len_zero;
		logic       zlp_pending;
		logic       rem_zero;
		logic       out_free;
	} sts_t;

endpackage

// File: rtl/core/usbfp_ctrl.sv
// Controller state machine: sequences one request through the datapath.
`timescale 1ns / 1ps
module usbfp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  usbfp_pkg::sts_t   sts,
	output usbfp_pkg::cmd_t   cmd
);
	import usbfp_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_TX_DATA,
		S_PLAN,
		S_PKT_RD,
		S_PKT_OUT,
		S_EMIT
	} state_t;

	state_t     state_q, state_d;
	logic [2:0] kind_q, kind_d;
	bsel_t      bsel_q, bsel_d;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		kind_d   = kind_q;
		bsel_d   = bsel_q;
		s_tready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.cap = 1'b1;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				kind_d  = KIND_DONE;
				bsel_d  = BSEL_ZERO;
				state_d = S_EMIT;
				unique case (sts.op)
					OP_HOST_IN: cmd.rx_push = 1'b1;
					OP_APP_READ: begin
						if (sts.rx_empty) begin
							kind_d = KIND_RD_EMPTY;
						end else begin
							cmd.rx_pop = 1'b1;
							kind_d     = KIND_RD_BYTE;
							bsel_d     = BSEL_RX;
						end
					end
					OP_APP_SEND: begin
						if (sts.cr_needed) begin
							cmd.tx_push_cr = 1'b1;
							state_d        = S_TX_DATA;
						end else begin
							cmd.tx_push_data = 1'b1;
						end
					end
					OP_FRAME: begin
						if (sts.tx_go) begin
							cmd.plan = 1'b1;
							state_d  = S_PLAN;
						end
					end
					OP_LINE: cmd.set_ls = 1'b1;
					default: ;
				endcase
			end
			S_TX_DATA: begin
				cmd.tx_push_data = 1'b1;
				state_d          = S_EMIT;
			end
			S_PLAN: begin
				if (sts.len_zero) begin
					if (sts.zlp_pending) begin
						cmd.zlp_clr = 1'b1;
						kind_d      = KIND_ZLP;
					end
					state_d = S_EMIT;
				end else begin
					state_d = S_PKT_RD;
				end
			end
			S_PKT_RD: begin
				cmd.tx_pop = 1'b1;
				state_d    = S_PKT_OUT;
			end
			S_PKT_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_kind = KIND_PKT_BYTE;
					cmd.out_bsel = BSEL_TX;
					cmd.out_last = sts.rem_zero;
					if (sts.rem_zero) begin
						cmd.zlp_upd = 1'b1;
						state_d     = S_IDLE;
					end else begin
						state_d = S_PKT_RD;
					end
				end
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_kind = kind_q;
					cmd.out_bsel = bsel_q;
					cmd.out_last = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kind_q  <= KIND_DONE;
			bsel_q  <= BSEL_ZERO;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
			bsel_q  <= bsel_d;
		end
	end

endmodule

// File: rtl/core/usbfp_dp.sv
// Datapath: request register, both byte stores, indices, packet planning, result register.
`timescale 1ns / 1ps
module usbfp_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [usbfp_pkg::S_DATA_W-1:0]    s_tdata,
	input  logic [2:0]                        s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [usbfp_pkg::M_DATA_W-1:0]    m_tdata,
	output logic [2:0]                        m_tuser,
	output logic                              m_tlast,
	input  logic                              cfg_we,
	input  logic [usbfp_pkg::MP_W-1:0]        cfg_data,
	input  usbfp_pkg::cmd_t                   cmd,
	output usbfp_pkg::sts_t                   sts
);
	import usbfp_pkg::*;

	// request fields
	logic [2:0]      op_q;
	logic [7:0]      data_q;
	logic            cooked_q;
	logic            dtr_q;
	logic            busy_q;
	logic            drop_q;

	logic [IW-1:0]   rx_w_q, rx_r_q, tx_w_q, tx_r_q;
	logic [IW-1:0]   rx_fill, tx_fill, tx_room, len_min;
	logic            rx_full, tx_full;
	logic            conn_q, zlp_q;
	logic [MP_W-1:0] mp_q, len_q, rem_q;

	logic [7:0]      rx_mem [FIFO_DEPTH];
	logic [7:0]      tx_mem [FIFO_DEPTH];
	logic [7:0]      rx_rd_q, tx_rd_q, tx_wr_byte, byte_sel;

	logic            vld_q;
	logic [2:0]      kind_q;
	logic [7:0]      byte_q;
	logic            last_q;
	logic [RXC_W-1:0] rxc_q;
	logic            odrop_q, oconn_q;

	assign rx_fill    = rx_w_q - rx_r_q;
	assign tx_fill    = tx_w_q - tx_r_q;
	assign rx_full    = rx_fill[AW];
	assign tx_full    = tx_fill[AW];
	assign tx_room    = IW'(FIFO_DEPTH) - {1'b0, tx_r_q[AW-1:0]};
	assign len_min    = (tx_fill < tx_room) ? tx_fill : tx_room;
	assign tx_wr_byte = cmd.tx_push_cr ? CHR_CR : data_q;

	always_comb begin
		unique case (cmd.out_bsel)
			BSEL_RX: byte_sel = rx_rd_q;
			BSEL_TX: byte_sel = tx_rd_q;
			default: byte_sel = '0;
		endcase
	end

	assign sts.op          = op_q;
	assign sts.cr_needed   = cooked_q && (data_q == CHR_LF);
	assign sts.rx_empty    = (rx_fill == '0);
	assign sts.tx_empty    = (tx_fill == '0);
	assign sts.tx_go       = conn_q && !busy_q;
	assign sts.len_zero    = (len_q == '0);
	assign sts.zlp_pending = zlp_q;
	assign sts.rem_zero    = (rem_q == '0);
	assign sts.out_free    = !vld_q || m_tready;

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			op_q     <= s_tuser;
			data_q   <= s_tdata[7:0];
			cooked_q <= s_tdata[8];
			dtr_q    <= s_tdata[9];
			busy_q   <= s_tdata[11];
		end
		if (cmd.plan) begin
			// packet length: queued bytes, clipped at the store end and at max_packet
			len_q <= (len_min < IW'(mp_q)) ? MP_W'(len_min) : mp_q;
			rem_q <= (len_min < IW'(mp_q)) ? MP_W'(len_min) : mp_q;
		end else if (cmd.tx_pop) begin
			rem_q <= rem_q - 1'b1;
		end
	end

	// byte stores
	always_ff @(posedge clk) begin
		if (cmd.rx_push && !rx_full) begin
			rx_mem[rx_w_q[AW-1:0]] <= data_q;
		end
		if (cmd.rx_pop) begin
			rx_rd_q <= rx_mem[rx_r_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if ((cmd.tx_push_cr || cmd.tx_push_data) && !tx_full) begin
			tx_mem[tx_w_q[AW-1:0]] <= tx_wr_byte;
		end
		if (cmd.tx_pop) begin
			tx_rd_q <= tx_mem[tx_r_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_w_q <= '0;
			rx_r_q <= '0;
			tx_w_q <= '0;
			tx_r_q <= '0;
			conn_q <= 1'b0;
			zlp_q  <= 1'b0;
			mp_q   <= MP_RESET;
			drop_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_data < MP_MIN) begin
					mp_q <= MP_MIN;
				end else if (cfg_data > MP_MAX) begin
					mp_q <= MP_MAX;
				end else begin
					mp_q <= cfg_data;
				end
			end
			if (cmd.cap) begin
				drop_q <= 1'b0;
			end else if ((cmd.rx_push && rx_full) ||
					((cmd.tx_push_cr || cmd.tx_push_data) && tx_full)) begin
				drop_q <= 1'b1;
			end
			if (cmd.rx_push && !rx_full) begin
				rx_w_q <= rx_w_q + 1'b1;
			end
			if (cmd.rx_pop) begin
				rx_r_q <= rx_r_q + 1'b1;
			end
			if ((cmd.tx_push_cr || cmd.tx_push_data) && !tx_full) begin
				tx_w_q <= tx_w_q + 1'b1;
			end
			if (cmd.tx_pop) begin
				tx_r_q <= tx_r_q + 1'b1;
			end
			if (cmd.set_ls) begin
				conn_q <= dtr_q;
			end
			if (cmd.zlp_clr) begin
				zlp_q <= 1'b0;
			end else if (cmd.zlp_upd) begin
				zlp_q <= (len_q == mp_q);
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (cmd.out_load) begin
			vld_q <= 1'b1;
		end else if (m_tready) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			kind_q  <= cmd.out_kind;
			byte_q  <= byte_sel;
			last_q  <= cmd.out_last;
			rxc_q   <= RXC_W'(rx_fill);
			odrop_q <= drop_q;
			oconn_q <= conn_q;
		end
	end

	assign m_tvalid = vld_q;
	assign m_tuser  = kind_q;
	assign m_tlast  = last_q;
	assign m_tdata  = {3'b000, oconn_q, odrop_q, rxc_q, byte_q};

endmodule

// File: rtl/core/usb_serial_bulk_fifo_packetizer_unit.sv
// USB serial bulk FIFO packetiser: top level joining controller and datapath.
`timescale 1ns / 1ps
// Two 1024-byte stores sit behind a USB serial bulk pipe: host bytes go into the receive
// store and are popped by the application; application bytes (with CR put before LF when
// cooked) go into the transmit store and leave as bulk IN packets on frame ticks. One
// request is handled at a time: a new one waits until the last has loaded its result. A
// host byte, read, line-state or unknown request passes the decode and emit states; a
// cooked line feed also passes the data write state. A frame tick plans the packet,
// then gives its bytes one at a time via the registered transmit store read. The
// output register lets a new request be accepted while the last result waits. Stores
// need no clearing pass after reset. max_packet writes are saturated into 8..64.
`include "assert_macros.svh"
module usb_serial_bulk_fifo_packetizer_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// data[7:0], cooked[8], line_state[10:9], ep_busy[11], zero fill[15:12]
	input  logic [usbfp_pkg::S_DATA_W-1:0]    s_tdata,
	// op[2:0]
	input  logic [2:0]                        s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// byte_out[7:0], rx_count[18:8], dropped[19], connected[20], zero fill[23:21]
	output logic [usbfp_pkg::M_DATA_W-1:0]    m_tdata,
	// kind[2:0]
	output logic [2:0]                        m_tuser,
	output logic                              m_tlast,
	input  logic                              cfg_we,
	input  logic [usbfp_pkg::MP_W-1:0]        cfg_data
);
	import usbfp_pkg::*;

	cmd_t cmd;
	sts_t sts;

	usbfp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	usbfp_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.sts      (sts)
	);

	`ASSERT_NEVER(a_load_while_full, clk, arst_n, cmd.out_load && !sts.out_free)
	`ASSERT_HOLDS(a_one_at_a_time, clk, arst_n, (s_tvalid && s_tready) |=> !s_tready)
	`ASSERT_NEVER(a_pop_empty_tx, clk, arst_n, cmd.tx_pop && sts.tx_empty)

endmodule
